>>> hdl/cvfr_pkg.sv
package cvfr_pkg;

  localparam int VEL_BITS      = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int GUARD_BITS    = 8;
  localparam int YAW_BITS      = 16;
  localparam int TICK_BITS     = 10;
  localparam int THR_BITS      = 8;
  localparam int CFG_BITS      = 10;
  localparam int INV_GAIN_BITS = 20;
  localparam int ATAN_W        = 23;
  localparam int ATAN_IDX_W    = 5;
  // Rotator word: guard bits, fold and CORDIC gain headroom, sign.
  localparam int XY_W          = VEL_BITS + GUARD_BITS + 3;
  // Angle word: folded phase fits in a quarter turn plus the atan sum.
  localparam int Z_W           = YAW_BITS + GUARD_BITS + 1;
  localparam int PROD_W        = XY_W + INV_GAIN_BITS + 1;
  localparam int ROUND_SH      = INV_GAIN_BITS + GUARD_BITS;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);

  localparam logic signed [INV_GAIN_BITS:0] INV_GAIN = (INV_GAIN_BITS + 1)'(636751);
  localparam logic signed [YAW_BITS:0]      QUARTER  = (YAW_BITS + 1)'(16384);
  localparam logic [TICK_BITS-1:0]          TICK_MAX = '1;

  typedef enum logic [2:0] {
    REQ_CMD  = 3'd0,
    REQ_YAW  = 3'd1,
    REQ_PLAN = 3'd2,
    REQ_TICK = 3'd3,
    REQ_SPIN = 3'd4
  } req_e;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_ZERO    = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MULX,
    ST_MULY,
    ST_FIN
  } state_e;

  // Arctangent of 2^-i in binary-angle units times 2^GUARD_BITS, rounded.
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 23'd2097152;
      5'd1:    v = 23'd1238021;
      5'd2:    v = 23'd654136;
      5'd3:    v = 23'd332050;
      5'd4:    v = 23'd166669;
      5'd5:    v = 23'd83416;
      5'd6:    v = 23'd41718;
      5'd7:    v = 23'd20860;
      5'd8:    v = 23'd10430;
      5'd9:    v = 23'd5215;
      5'd10:   v = 23'd2608;
      5'd11:   v = 23'd1304;
      5'd12:   v = 23'd652;
      5'd13:   v = 23'd326;
      5'd14:   v = 23'd163;
      5'd15:   v = 23'd81;
      5'd16:   v = 23'd41;
      5'd17:   v = 23'd20;
      5'd18:   v = 23'd10;
      5'd19:   v = 23'd5;
      5'd20:   v = 23'd3;
      5'd21:   v = 23'd1;
      5'd22:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

  // Round half up, drop guard and gain bits, saturate to a velocity word.
  function automatic logic signed [VEL_BITS-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (ROUND_SH - 1);
    localparam logic signed [PROD_W-1:0] PMAX = PROD_W'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_W-1:0] PMIN = -PMAX - PROD_W'(1);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] r;
    s = p + HALF;
    r = s >>> ROUND_SH;
    if (r > PMAX) r = PMAX;
    else if (r < PMIN) r = PMIN;
    return VEL_BITS'(r);
  endfunction

  function automatic logic signed [VEL_BITS-1:0] sat_sum(input logic signed [VEL_BITS:0] v);
    localparam logic signed [VEL_BITS:0] SMAX = (VEL_BITS + 1)'((64'sd1 <<< (VEL_BITS - 1)) - 64'sd1);
    localparam logic signed [VEL_BITS:0] SMIN = -SMAX - (VEL_BITS + 1)'(1);
    logic signed [VEL_BITS:0] r;
    r = v;
    if (r > SMAX) r = SMAX;
    else if (r < SMIN) r = SMIN;
    return VEL_BITS'(r);
  endfunction

  function automatic logic [VEL_BITS:0] vel_mag(input logic signed [VEL_BITS-1:0] v);
    logic signed [VEL_BITS:0] s;
    s = (VEL_BITS + 1)'(v);
    if (s < 0) s = -s;
    return VEL_BITS'(0) | s;
  endfunction

endpackage

>>> hdl/chassis_velocity_frame_rotator_top.sv
// Rotating word (direct command send, or a cached command on a tick): the input stalls until
// the sequencer is back in idle; the result word is loaded in the final state after 16 CORDIC
// steps on one shared add/shift unit and x then y on one shared gain multiplier. Stop result:
// input stalls while the final state loads the result, with no rotation or multiply.
// Words that send nothing go back to back, one per cycle. A waiting result word holds the
// sequencer in its final state until taken. Reset clears yaw, spin, cache valid and output
// valid, loads timeout 50 and threshold 1, and sets the tick counter to its maximum.
module chassis_velocity_frame_rotator_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [cvfr_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [2:0]                           req_type_i,
  input  logic signed [cvfr_pkg::VEL_BITS-1:0] lin_x_i,
  input  logic signed [cvfr_pkg::VEL_BITS-1:0] lin_y_i,
  input  logic signed [cvfr_pkg::VEL_BITS-1:0] ang_z_i,
  input  logic signed [cvfr_pkg::YAW_BITS-1:0] yaw_angle_i,
  input  logic signed [cvfr_pkg::VEL_BITS-1:0] spin_rate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cvfr_pkg::VEL_BITS-1:0] out_lin_x_o,
  output logic signed [cvfr_pkg::VEL_BITS-1:0] out_lin_y_o,
  output logic signed [cvfr_pkg::VEL_BITS-1:0] out_ang_z_o,
  output logic                                 is_stop_o
);
  import cvfr_pkg::*;

  // Control and configuration state
  state_e                     state_q, state_d;
  logic [TICK_BITS-1:0]       timeout_q;
  logic [THR_BITS-1:0]        thr_q;
  logic [TICK_BITS-1:0]       ticks_q;
  logic signed [YAW_BITS-1:0] yaw_q;
  logic signed [VEL_BITS-1:0] spin_q;
  logic                       cache_vld_q;
  logic                       out_vld_q;

  // Cache and datapath payload
  logic signed [VEL_BITS-1:0] cx_q, cy_q, cw_q;
  logic signed [XY_W-1:0]     x_q, y_q;
  logic signed [Z_W-1:0]      z_q;
  logic [STEP_W-1:0]          cnt_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [VEL_BITS-1:0] rx_q;
  logic signed [VEL_BITS-1:0] ang_q;
  logic                       stop_q;
  logic signed [VEL_BITS-1:0] ox_q, oy_q, ow_q;
  logic                       os_q;

  logic acc, timed, cmd_zero, start_rot, start_stop, out_free;
  logic [TICK_BITS-1:0] tick_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign timed      = ticks_q > timeout_q;
  assign tick_inc   = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + TICK_BITS'(1);

  // A component counts as zero below the threshold; a zero threshold matches nothing.
  assign cmd_zero = (vel_mag(lin_x_i) < (VEL_BITS + 1)'(thr_q)) &&
                    (vel_mag(lin_y_i) < (VEL_BITS + 1)'(thr_q)) &&
                    (vel_mag(ang_z_i) < (VEL_BITS + 1)'(thr_q));

  // Decide what an accepted word starts.
  always_comb begin
    start_rot  = 1'b0;
    start_stop = 1'b0;
    case (req_type_i)
      REQ_CMD:  start_rot = cmd_zero || timed;
      REQ_TICK: begin
        if (cache_vld_q) begin
          start_stop = tick_inc > timeout_q;
          start_rot  = !(tick_inc > timeout_q);
        end
      end
      default: ;
    endcase
  end

  // Select source velocity: the cache on a tick, the input otherwise.
  logic signed [VEL_BITS-1:0] sx, sy, sw;
  assign sx = (req_type_i == REQ_TICK) ? cx_q : lin_x_i;
  assign sy = (req_type_i == REQ_TICK) ? cy_q : lin_y_i;
  assign sw = (req_type_i == REQ_TICK) ? cw_q : ang_z_i;

  // Fold the angle into plus or minus a quarter turn by an exact 90 degree swap.
  logic signed [XY_W-1:0]     ex, ey, fx, fy;
  logic signed [YAW_BITS:0]   phi, phi_f;
  logic signed [Z_W-1:0]      z0;
  always_comb begin
    ex  = XY_W'(sx) <<< GUARD_BITS;
    ey  = XY_W'(sy) <<< GUARD_BITS;
    phi = -((YAW_BITS + 1)'(yaw_q));
    fx  = ex;
    fy  = ey;
    phi_f = phi;
    if (phi > QUARTER) begin
      fx    = -ey;
      fy    = ex;
      phi_f = phi - QUARTER;
    end else if (phi < -QUARTER) begin
      fx    = ey;
      fy    = -ex;
      phi_f = phi + QUARTER;
    end
    z0 = Z_W'(phi_f) <<< GUARD_BITS;
  end

  // Shared CORDIC step: one add/subtract per coordinate and a barrel shift.
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  atan_z;
  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_z = Z_W'(atan_lut(ATAN_IDX_W'(cnt_q)));

  // Shared gain multiplier: x first, then y.
  logic signed [PROD_W-1:0] mul_a, mul_g, prod_d;
  assign mul_a  = (state_q == ST_MULX) ? PROD_W'(x_q) : PROD_W'(y_q);
  assign mul_g  = PROD_W'(INV_GAIN);
  assign prod_d = mul_a * mul_g;

  logic signed [VEL_BITS:0] ang_sum;
  assign ang_sum = (VEL_BITS + 1)'(sw) + (VEL_BITS + 1)'(spin_q);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && start_rot)       state_d = ST_ROT;
        else if (acc && start_stop) state_d = ST_FIN;
      end
      ST_ROT:  if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) state_d = ST_MULX;
      ST_MULX: state_d = ST_MULY;
      ST_MULY: state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TICK_BITS'(50);
      thr_q       <= THR_BITS'(1);
      ticks_q     <= TICK_MAX;
      yaw_q       <= '0;
      spin_q      <= '0;
      cache_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_e'(cfg_idx_i))
          CFG_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_ZERO:    thr_q     <= cfg_data_i[THR_BITS-1:0];
          default: ;
        endcase
      end
      if (acc) begin
        case (req_type_i)
          REQ_CMD:  if (!start_rot) cache_vld_q <= 1'b1;
          REQ_YAW:  if (timed) yaw_q <= yaw_angle_i;
          REQ_PLAN: ticks_q <= '0;
          REQ_TICK: begin
            ticks_q <= tick_inc;
            if (start_stop) cache_vld_q <= 1'b0;
          end
          REQ_SPIN: spin_q <= spin_rate_i;
          default: ;
        endcase
      end
    end
  end

  // Cache and rotator payload
  always_ff @(posedge clk_i) begin
    if (acc && (req_type_i == REQ_CMD) && !start_rot) begin
      cx_q <= lin_x_i;
      cy_q <= lin_y_i;
      cw_q <= ang_z_i;
    end
    case (state_q)
      ST_IDLE: begin
        x_q    <= fx;
        y_q    <= fy;
        z_q    <= z0;
        cnt_q  <= '0;
        ang_q  <= sat_sum(ang_sum);
        stop_q <= start_stop;
      end
      ST_ROT: begin
        if (!z_q[Z_W-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_z;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_z;
        end
        cnt_q <= cnt_q + STEP_W'(1);
      end
      ST_MULX: prod_q <= prod_d;
      ST_MULY: begin
        rx_q   <= rnd_sat(prod_q);
        prod_q <= prod_d;
      end
      default: ;
    endcase
  end

  // Output register: load in the final state once the slot is free.
  logic load_out;
  assign load_out = (state_q == ST_FIN) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                       out_vld_q <= 1'b0;
    else if (load_out)                 out_vld_q <= 1'b1;
    else if (out_vld_q && !out_stall_i) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ox_q <= stop_q ? '0 : rx_q;
      oy_q <= stop_q ? '0 : rnd_sat(prod_q);
      ow_q <= stop_q ? '0 : ang_q;
      os_q <= stop_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_lin_x_o = ox_q;
  assign out_lin_y_o = oy_q;
  assign out_ang_z_o = ow_q;
  assign is_stop_o   = os_q;

endmodule
